// ----- hw/rtl/ggb_pkg.sv -----
// Shared types and constants for the Gabriel graph builder.
// No dependencies; the interfaces, the top level, the checker and the testbench import this package.
`default_nettype none

package ggb_pkg;

  // Fixed field widths of the point and edge transfers
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned IDX_W       = 4;
  // Edge list is cut after this many results
  localparam int unsigned MAX_RESULTS = 60;

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               final_point;
  } point_t;

  typedef struct packed {
    logic             has_edge;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             final_edge;
  } edge_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ggb_point_if.sv -----
// Valid/ready channel carrying one input point per transfer.
// Depends on ggb_pkg for the payload type.
`default_nettype none

interface ggb_point_if;
  import ggb_pkg::*;

  logic   valid;
  logic   ready;
  point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ggb_edge_if.sv -----
// Valid/ready channel carrying one graph edge result per transfer.
// Depends on ggb_pkg for the payload type.
`default_nettype none

interface ggb_edge_if;
  import ggb_pkg::*;

  logic  valid;
  logic  ready;
  edge_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ggb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ggb_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ggb_sq_unit.sv -----
// Shared squaring unit: registered square of the magnitude of a signed difference.
// No dependencies.
`default_nettype none

module ggb_sq_unit #(
  parameter int unsigned DW = 18
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [DW-1:0] diff_i,
  output logic          [2*DW-3:0]  prod_o
);

  logic [DW-1:0] neg;
  logic [DW-2:0] mag;

  // magnitude never reaches the most negative code, so DW-1 bits suffice
  assign neg = -diff_i;
  assign mag = diff_i[DW-1] ? neg[DW-2:0] : diff_i[DW-2:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= mag * mag;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gabriel_graph_builder.sv -----
// Gabriel graph builder top level.
// Depends on ggb_pkg, ggb_point_if, ggb_edge_if, ggb_ram and ggb_sq_unit.
`default_nettype none

// Points are taken one per cycle while the block is idle and are stored in
// arrival order (index 0 first); points beyond MAX_POINTS are dropped. A point
// with final_point set starts construction: every pair i<j is tested against
// every other stored point p with the exact test |2p-a-b|^2 <= |a-b|^2, using
// one shared squarer and a point RAM with one write port and one read port
// under a small sequencer. For each pair the sequencer fetches both points and
// forms the diameter, then reads, squares and compares each witness in turn;
// a blocked pair stops at its first blocking witness. Edges come out in
// ascending i, then j, the last one flagged final_edge; an empty graph gives
// one result with has_edge low. The input is not ready during construction;
// the output register lets the final result wait while new points are loaded.
module gabriel_graph_builder #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ggb_point_if.sink  pt_i,
  ggb_edge_if.source edge_o
);
  import ggb_pkg::*;

  localparam int unsigned CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned RW = $clog2(MAX_RESULTS + 1);
  localparam int unsigned DW = CW + 2;
  localparam int unsigned PW = 2 * CW + 2;
  localparam int unsigned SW = 2 * CW + 3;

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PAIR_RA = 4'd1;
  localparam logic [3:0] ST_PAIR_RB = 4'd2;
  localparam logic [3:0] ST_PAIR_LB = 4'd3;
  localparam logic [3:0] ST_DIAM_X  = 4'd4;
  localparam logic [3:0] ST_DIAM_Y  = 4'd5;
  localparam logic [3:0] ST_DIAM_S  = 4'd6;
  localparam logic [3:0] ST_WIT_CHK = 4'd7;
  localparam logic [3:0] ST_WIT_X   = 4'd8;
  localparam logic [3:0] ST_WIT_Y   = 4'd9;
  localparam logic [3:0] ST_WIT_S   = 4'd10;
  localparam logic [3:0] ST_EDGE    = 4'd11;
  localparam logic [3:0] ST_ADV     = 4'd12;
  localparam logic [3:0] ST_FLUSH   = 4'd13;

  // control state
  logic [3:0]    state_q, state_d;
  logic [NW-1:0] count_q, count_d;
  logic [NW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [RW-1:0] cnt_q, cnt_d;
  logic          pend_vld_q, pend_vld_d;
  logic          out_vld_q, out_vld_d;

  // datapath registers
  logic [CW-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [CW:0]   sx_q, sx_d, sy_q, sy_d;
  logic [CW-1:0] py_q, py_d;
  logic [SW-1:0] acc_q, acc_d, diam_q, diam_d;
  logic [NW-1:0] pend_i_q, pend_i_d, pend_j_q, pend_j_d;
  edge_t         out_q, out_d;

  // memory and squarer hookup
  logic                 in_xfer;
  logic                 wr_en;
  logic [2*CW-1:0]      wdata;
  logic [AW-1:0]        raddr;
  logic [2*CW-1:0]      rdata;
  logic [CW-1:0]        rd_x, rd_y;
  logic                 sq_en;
  logic signed [DW-1:0] sq_diff;
  logic [PW-1:0]        prod;
  logic [SW-1:0]        sum;
  logic                 out_free;
  logic [NW:0]          j_next, i_next;

  assign in_xfer  = pt_i.valid && pt_i.ready;
  assign pt_i.ready = (state_q == ST_IDLE);
  assign edge_o.valid = out_vld_q;
  assign edge_o.data  = out_q;
  assign out_free = !out_vld_q || edge_o.ready;

  // point store: x in the low half, y in the high half
  assign wr_en = in_xfer && (count_q < NW'(MAX_POINTS));
  assign wdata = {pt_i.data.y_coord[CW-1:0], pt_i.data.x_coord[CW-1:0]};
  assign rd_x  = rdata[CW-1:0];
  assign rd_y  = rdata[2*CW-1:CW];

  always_comb begin
    case (state_q)
      ST_PAIR_RA: raddr = i_q[AW-1:0];
      ST_PAIR_RB: raddr = j_q[AW-1:0];
      default:    raddr = k_q[AW-1:0];
    endcase
  end

  ggb_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // operand select for the shared squarer
  always_comb begin
    sq_en = 1'b1;
    case (state_q)
      ST_DIAM_X: sq_diff = {2'b00, ax_q} - {2'b00, bx_q};
      ST_DIAM_Y: sq_diff = {2'b00, ay_q} - {2'b00, by_q};
      ST_WIT_X:  sq_diff = {1'b0, rd_x, 1'b0} - {1'b0, sx_q};
      ST_WIT_Y:  sq_diff = {1'b0, py_q, 1'b0} - {1'b0, sy_q};
      default: begin
        sq_diff = '0;
        sq_en   = 1'b0;
      end
    endcase
  end

  ggb_sq_unit #(
    .DW (DW)
  ) u_sq (
    .clk_i  (clk_i),
    .en_i   (sq_en),
    .diff_i (sq_diff),
    .prod_o (prod)
  );

  assign sum    = acc_q + SW'(prod);
  assign j_next = {1'b0, j_q} + 1'b1;
  assign i_next = {1'b0, i_q} + 1'b1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = out_vld_q && !edge_o.ready;
    ax_d       = ax_q;
    ay_d       = ay_q;
    bx_d       = bx_q;
    by_d       = by_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    py_d       = py_q;
    acc_d      = acc_q;
    diam_d     = diam_q;
    pend_i_d   = pend_i_q;
    pend_j_d   = pend_j_q;
    out_d      = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (wr_en) begin
            count_d = count_q + 1'b1;
          end
          if (pt_i.data.final_point) begin
            i_d = '0;
            j_d = NW'(1);
            if (count_d < NW'(2)) begin
              state_d = ST_FLUSH;
            end else begin
              state_d = ST_PAIR_RA;
            end
          end
        end
      end
      ST_PAIR_RA: state_d = ST_PAIR_RB;
      ST_PAIR_RB: begin
        ax_d    = rd_x;
        ay_d    = rd_y;
        state_d = ST_PAIR_LB;
      end
      ST_PAIR_LB: begin
        bx_d    = rd_x;
        by_d    = rd_y;
        state_d = ST_DIAM_X;
      end
      ST_DIAM_X: begin
        sx_d    = {1'b0, ax_q} + {1'b0, bx_q};
        sy_d    = {1'b0, ay_q} + {1'b0, by_q};
        state_d = ST_DIAM_Y;
      end
      ST_DIAM_Y: begin
        acc_d   = SW'(prod);
        state_d = ST_DIAM_S;
      end
      ST_DIAM_S: begin
        diam_d  = sum;
        k_d     = '0;
        state_d = ST_WIT_CHK;
      end
      // walk witnesses, skipping the pair's own endpoints
      ST_WIT_CHK: begin
        if (k_q == count_q) begin
          state_d = ST_EDGE;
        end else if (k_q == i_q || k_q == j_q) begin
          k_d = k_q + 1'b1;
        end else begin
          state_d = ST_WIT_X;
        end
      end
      ST_WIT_X: begin
        py_d    = rd_y;
        state_d = ST_WIT_Y;
      end
      ST_WIT_Y: begin
        acc_d   = SW'(prod);
        state_d = ST_WIT_S;
      end
      ST_WIT_S: begin
        if (sum <= diam_q) begin
          state_d = ST_ADV;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_WIT_CHK;
        end
      end
      // one edge is held back so the last one can carry the final flag
      ST_EDGE: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d          = 1'b1;
            out_d.has_edge     = 1'b1;
            out_d.first_index  = IDX_W'(pend_i_q);
            out_d.second_index = IDX_W'(pend_j_q);
            out_d.final_edge   = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_i_d   = i_q;
          pend_j_d   = j_q;
          cnt_d      = cnt_q + 1'b1;
          if (RW'(cnt_q + 1'b1) == RW'(MAX_RESULTS)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        if (j_next < {1'b0, count_q}) begin
          j_d     = j_next[NW-1:0];
          state_d = ST_PAIR_RA;
        end else if ((i_next + 1'b1) < {1'b0, count_q}) begin
          i_d     = i_next[NW-1:0];
          j_d     = NW'(i_next + 1'b1);
          state_d = ST_PAIR_RA;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_vld_d          = 1'b1;
          out_d.has_edge     = pend_vld_q;
          out_d.first_index  = pend_vld_q ? IDX_W'(pend_i_q) : '0;
          out_d.second_index = pend_vld_q ? IDX_W'(pend_j_q) : '0;
          out_d.final_edge   = 1'b1;
          pend_vld_d         = 1'b0;
          count_d            = '0;
          cnt_d              = '0;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    py_q     <= py_d;
    acc_q    <= acc_d;
    diam_q   <= diam_d;
    pend_i_q <= pend_i_d;
    pend_j_q <= pend_j_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ggb_checker.sv -----
// Port-level checks for the Gabriel graph builder, bound to the top level.
// Depends on ggb_pkg and gabriel_graph_builder.
`default_nettype none

module ggb_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           in_final_i,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire ggb_pkg::edge_t out_data_i
);
  import ggb_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // construction starts right after the final point transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("input still ready after final point");

  // the empty-graph result is always final and carries zero indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.has_edge |->
      out_data_i.final_edge && out_data_i.first_index == '0 &&
      out_data_i.second_index == '0)
    else $error("malformed empty-graph result");

endmodule

bind gabriel_graph_builder ggb_checker u_ggb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .in_final_i  (pt_i.data.final_point),
  .out_valid_i (edge_o.valid),
  .out_ready_i (edge_o.ready),
  .out_data_i  (edge_o.data)
);

`default_nettype wire

// ----- tb/sv/tb_gabriel_graph_builder.sv -----
// Self-checking testbench for gabriel_graph_builder: directed point sets, then random ones.
// Depends on ggb_pkg, ggb_point_if, ggb_edge_if and the block's RTL.
// Expected edges come from a brute-force Gabriel predictor kept inside this file.
`default_nettype none

module tb_gabriel_graph_builder;
  import ggb_pkg::*;

  localparam int unsigned NUM_SLOTS      = 16;
  localparam int unsigned RANDOM_ITEMS   = 300;
  localparam int unsigned DRAIN_CYCLES   = 64;
  // 16 points: 120 pairs, each tested against every other point, plus long stalls, with margin
  localparam int unsigned WATCHDOG_LIMIT = 50000;

  // Directed rows: a point, and for one-result sets the result read off directly
  typedef struct packed {
    point_t pt;
    logic   typed;
    edge_t  res;
  } stim_row_t;

  localparam edge_t NO_RES    = '0;
  localparam edge_t EMPTY_SET = '{1'b0, 4'd0, 4'd0, 1'b1};
  localparam edge_t EDGE_01   = '{1'b1, 4'd0, 4'd1, 1'b1};

  localparam int unsigned NUM_DIR = 19;
  localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
    // lone point after reset: empty graph
    '{'{16'h1234, 16'h5678, 1'b1}, 1'b1, EMPTY_SET},
    // opposite corners
    '{'{16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RES},
    '{'{16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, EDGE_01},
    // three coincident points block every pair
    '{'{16'hFFFF, 16'h0000, 1'b0}, 1'b0, NO_RES},
    '{'{16'hFFFF, 16'h0000, 1'b0}, 1'b0, NO_RES},
    '{'{16'hFFFF, 16'h0000, 1'b1}, 1'b1, EMPTY_SET},
    // two coincident points alone still form an edge
    '{'{16'h8000, 16'h8000, 1'b0}, 1'b0, NO_RES},
    '{'{16'h8000, 16'h8000, 1'b1}, 1'b1, EDGE_01},
    // alternating bit patterns
    '{'{16'hAAAA, 16'h5555, 1'b0}, 1'b0, NO_RES},
    '{'{16'h5555, 16'hAAAA, 1'b1}, 1'b1, EDGE_01},
    // witness exactly on the circle blocks the pair
    '{'{16'd0, 16'd0, 1'b0}, 1'b0, NO_RES},
    '{'{16'd4, 16'd0, 1'b0}, 1'b0, NO_RES},
    '{'{16'd2, 16'd2, 1'b1}, 1'b0, NO_RES},
    // collinear: midpoint blocks the outer pair
    '{'{16'd0, 16'd0, 1'b0}, 1'b0, NO_RES},
    '{'{16'd10, 16'd0, 1'b0}, 1'b0, NO_RES},
    '{'{16'd20, 16'd0, 1'b1}, 1'b0, NO_RES},
    // witness just outside the circle
    '{'{16'd0, 16'd0, 1'b0}, 1'b0, NO_RES},
    '{'{16'd4, 16'd0, 1'b0}, 1'b0, NO_RES},
    '{'{16'd2, 16'd3, 1'b1}, 1'b0, NO_RES}
  };

  logic clk_i;
  logic rst_ni;

  ggb_point_if pt_if ();
  ggb_edge_if  edge_if ();

  gabriel_graph_builder #(
    .MAX_POINTS(NUM_SLOTS),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_if.sink),
    .edge_o(edge_if.source)
  );

  // Clock, period 4
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Predictor state: stored points and pending edge results
  logic [COORD_W-1:0] store_x [NUM_SLOTS];
  logic [COORD_W-1:0] store_y [NUM_SLOTS];
  int unsigned        stored_cnt;
  edge_t              pending_edges [$];

  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int          stall_left;
  bit          calm;
  edge_t       want;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Gaps for both sides: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // True when no other stored point lies in or on the circle with diameter a-b
  function automatic bit gabriel_pair(input int unsigned a, input int unsigned b,
                                      input int unsigned n);
    longint ax, ay, bx, by, diam, ex, ey;
    ax = store_x[a];
    ay = store_y[a];
    bx = store_x[b];
    by = store_y[b];
    diam = (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    for (int unsigned k = 0; k < n; k++) begin
      if (k != a && k != b) begin
        ex = 2 * longint'(store_x[k]) - ax - bx;
        ey = 2 * longint'(store_y[k]) - ay - by;
        if (ex * ex + ey * ey <= diam) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Store an accepted point; on the final one, queue the set's edge list
  task automatic absorb_point(input point_t p, input bit typed, input edge_t typed_res);
    edge_t found [$];
    edge_t e;
    int unsigned n;
    if (stored_cnt < NUM_SLOTS) begin
      store_x[stored_cnt] = p.x_coord;
      store_y[stored_cnt] = p.y_coord;
      stored_cnt++;
    end
    if (!p.final_point) return;
    n = stored_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = i + 1; j < n; j++) begin
        if (found.size() < MAX_RESULTS && gabriel_pair(i, j, n)) begin
          e = '{1'b1, IDX_W'(i), IDX_W'(j), 1'b0};
          found = {found, e};
        end
      end
    end
    if (found.size() == 0) found = {found, EMPTY_SET};
    else found[found.size()-1].final_edge = 1'b1;
    stored_cnt = 0;
    if (typed) pending_edges = {pending_edges, typed_res};
    else foreach (found[k]) pending_edges = {pending_edges, found[k]};
  endtask

  // Offer one point and wait for its transfer
  task automatic send_point(input point_t p, input bit typed, input edge_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.data  <= p;
    do @(posedge clk_i); while (!pt_if.ready);
    absorb_point(p, typed, typed_res);
  endtask

  // Coordinate styles: full range, tiny (coincident and on-circle hits), coarse grid
  function automatic logic [COORD_W-1:0] rand_coord(input int unsigned style);
    int unsigned g;
    case (style)
      2: begin
        return COORD_W'($urandom_range(0, 7));
      end
      3: begin
        g = $urandom_range(0, 4);
        return (g == 4) ? {COORD_W{1'b1}} : COORD_W'(g * 16384);
      end
      default: begin
        return COORD_W'($urandom);
      end
    endcase
  endfunction

  // Receiver: ready with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      edge_if.ready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      edge_if.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      edge_if.ready <= 1'b1;
      stall_left    <= pick_gap();
    end
  end

  // Result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && edge_if.valid && edge_if.ready) begin
      if (pending_edges.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", edge_if.data));
      end else begin
        want = pending_edges.pop_front();
        if (edge_if.data.has_edge !== want.has_edge)
          report_mismatch($sformatf("has_edge got %b want %b",
                                    edge_if.data.has_edge, want.has_edge));
        if (edge_if.data.first_index !== want.first_index)
          report_mismatch($sformatf("first_index got %0d want %0d",
                                    edge_if.data.first_index, want.first_index));
        if (edge_if.data.second_index !== want.second_index)
          report_mismatch($sformatf("second_index got %0d want %0d",
                                    edge_if.data.second_index, want.second_index));
        if (edge_if.data.final_edge !== want.final_edge)
          report_mismatch($sformatf("final_edge got %b want %b",
                                    edge_if.data.final_edge, want.final_edge));
      end
    end
    if ((pt_if.valid && pt_if.ready) || (edge_if.valid && edge_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int unsigned sent, set_size, style;
    point_t p;
    stored_cnt    = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    pt_if.valid   = 1'b0;
    pt_if.data    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int unsigned r = 0; r < NUM_DIR; r++)
      send_point(DIR_ROWS[r].pt, DIR_ROWS[r].typed, DIR_ROWS[r].res);

    // Random point sets; the first one overfills the store
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0) begin
        set_size = 18;
      end else begin
        case ($urandom_range(0, 19)) inside
          [0:12]:  set_size = $urandom_range(1, 6);
          [13:16]: set_size = $urandom_range(7, 16);
          default: set_size = $urandom_range(17, 20);
        endcase
      end
      style = $urandom_range(0, 3);
      calm  = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < set_size; k++) begin
        p.x_coord     = rand_coord(style);
        p.y_coord     = rand_coord(style);
        p.final_point = (k == set_size - 1);
        send_point(p, 1'b0, NO_RES);
      end
      sent += set_size;
    end
    pt_if.valid <= 1'b0;
    calm = 1'b0;

    // Drain, then watch for strays
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
